/* src/camera_point_to_pixel_defines.svh */
// Assertion macros for the camera point-to-pixel block.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CAMERA_POINT_TO_PIXEL_DEFINES_SVH
`define CAMERA_POINT_TO_PIXEL_DEFINES_SVH
`ifndef SYNTH
`define CP2P_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cp2p assertion failed");
`define CP2P_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cp2p assertion failed");
`else
`define CP2P_ASSERT(lbl, prop)
`define CP2P_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/cp2p_pkg.sv */
// Shared constants and fixed-point helper functions for the point-to-pixel block.
// No dependencies.
package cp2p_pkg;

    localparam int QUOT_W = 32;

    localparam logic [2:0] REG_K1    = 3'd0;
    localparam logic [2:0] REG_K2    = 3'd1;
    localparam logic [2:0] REG_P1    = 3'd2;
    localparam logic [2:0] REG_P2    = 3'd3;
    localparam logic [2:0] REG_FX    = 3'd4;
    localparam logic [2:0] REG_FY    = 3'd5;
    localparam logic [2:0] REG_PP    = 3'd6;
    localparam logic [2:0] REG_LIMIT = 3'd7;

    localparam logic [1:0] ST_INSIDE  = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_BEHIND  = 2'd2;
    localparam logic [1:0] ST_LIMIT   = 2'd3;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    // Finishes a Q4.28 product from its magnitude and sign: truncate, then saturate.
    function automatic logic signed [31:0] qfin(input logic [63:0] p, input logic neg);
        logic [35:0] m;
        m = p[63:28];
        if (neg)
            return (m > 36'h0_8000_0000) ? 32'h8000_0000 : 32'(~m[31:0] + 32'd1);
        else
            return (m > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic logic signed [31:0] qsat(input logic [31:0] q, input logic ovf,
                                                input logic neg);
        if (neg)
            return (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(~q + 32'd1);
        else
            return (ovf || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    endfunction

endpackage

/* src/cp2p_div.sv */
// Pipelined restoring divider: (num_mag * 2^28) / den, one quotient bit per stage.
// Depends on cp2p_pkg for the quotient width.
module cp2p_div (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num_mag,
    input  logic [30:0] den,
    output logic [31:0] quot,
    output logic        ovf
);
    import cp2p_pkg::*;

    logic [30:0]       rem_reg [0:QUOT_W];
    logic [30:0]       den_reg [0:QUOT_W];
    logic [QUOT_W-1:0] low_reg [0:QUOT_W];
    logic [QUOT_W-1:0] q_reg   [0:QUOT_W];
    logic              ovf_reg [0:QUOT_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {3'b000, num_mag[31:4]};
            den_reg[0] <= den;
            low_reg[0] <= {num_mag[3:0], 28'd0};
            q_reg[0]   <= '0;
            ovf_reg[0] <= {3'b000, num_mag[31:4]} >= den;
        end
    end

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        logic [31:0]       trial;
        logic [31:0]       diff;
        logic              ge;
        logic [30:0]       rem_next;
        always_comb
        begin
            trial    = {rem_reg[k], low_reg[k][QUOT_W-1]};
            diff     = trial - {1'b0, den_reg[k]};
            ge       = trial >= {1'b0, den_reg[k]};
            rem_next = ge ? diff[30:0] : trial[30:0];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                den_reg[k+1] <= den_reg[k];
                low_reg[k+1] <= {low_reg[k][QUOT_W-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][QUOT_W-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign quot = q_reg[QUOT_W];
    assign ovf  = ovf_reg[QUOT_W];

endmodule

/* src/camera_point_to_pixel.sv */
// Projects camera-frame points (Q16.16) through a pinhole model with radial and tangential
// lens distortion to pixel positions (Q24.8) with an in-image status. One transaction is
// accepted per clock unless stalled; each result passes through the 33-stage bit-per-stage
// depth divider, then ten multiply/saturate stages and the output register. A stall on
// the output freezes the whole pipeline. Depends on cp2p_pkg, cp2p_div and the defines header.
`include "camera_point_to_pixel_defines.svh"
module camera_point_to_pixel #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // pixel_x, pixel_y
    output logic [1:0]  m_tuser,    // status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata
);
    import cp2p_pkg::*;

    localparam logic signed [35:0] X_END = 36'(IMAGE_WIDTH * 256);
    localparam logic signed [35:0] Y_END = 36'(IMAGE_HEIGHT * 256);

    logic signed [31:0] k1_reg, k2_reg, p1_reg, p2_reg;
    logic [31:0]        fx_reg, fy_reg, limit_reg;
    logic [47:0]        pp_reg;
    logic               distorted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg    <= '0;
            k2_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            fx_reg    <= '0;
            fy_reg    <= '0;
            pp_reg    <= '0;
            limit_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_K1:    k1_reg    <= cfg_wdata[31:0];
                REG_K2:    k2_reg    <= cfg_wdata[31:0];
                REG_P1:    p1_reg    <= cfg_wdata[31:0];
                REG_P2:    p2_reg    <= cfg_wdata[31:0];
                REG_FX:    fx_reg    <= cfg_wdata[31:0];
                REG_FY:    fy_reg    <= cfg_wdata[31:0];
                REG_PP:    pp_reg    <= cfg_wdata;
                REG_LIMIT: limit_reg <= cfg_wdata[31:0];
                default:   ;
            endcase
        end
    end

    assign distorted = (k1_reg != 0) || (k2_reg != 0) || (p1_reg != 0) || (p2_reg != 0);

    logic               m_tvalid_reg;
    logic               adv;
    logic signed [31:0] in_x, in_y, in_z;
    logic               in_behind;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign in_z     = s_tdata[95:64];
    assign in_behind = in_z[31] || (in_z == 0);

    logic [31:0] qx, qy;
    logic        ovfx, ovfy;

    cp2p_div u_div_x (
        .clk(clk), .en(adv), .num_mag(mag32(in_x)),
        .den(in_behind ? 31'd1 : in_z[30:0]), .quot(qx), .ovf(ovfx)
    );
    cp2p_div u_div_y (
        .clk(clk), .en(adv), .num_mag(mag32(in_y)),
        .den(in_behind ? 31'd1 : in_z[30:0]), .quot(qy), .ovf(ovfy)
    );

    // Control that rides alongside the divider stages.
    logic v_reg  [0:QUOT_W];
    logic bh_reg [0:QUOT_W];
    logic sx_reg [0:QUOT_W];
    logic sy_reg [0:QUOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QUOT_W; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_tvalid;
            for (int i = 0; i < QUOT_W; i++)
                v_reg[i+1] <= v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bh_reg[0] <= in_behind;
            sx_reg[0] <= in_x[31];
            sy_reg[0] <= in_y[31];
            for (int i = 0; i < QUOT_W; i++)
            begin
                bh_reg[i+1] <= bh_reg[i];
                sx_reg[i+1] <= sx_reg[i];
                sy_reg[i+1] <= sy_reg[i];
            end
        end
    end

    // Post-divide stages A..J plus output; bit 0 is stage A, bit 10 the output.
    logic [10:0] pv_reg;
    logic [9:0]  pbh_reg;
    logic [7:0]  plim_reg;   // bit 0 is stage C

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= {pv_reg[9:0], v_reg[QUOT_W]};
    end

    assign m_tvalid_reg = pv_reg[10];

    logic signed [31:0] nx_a, ny_a, nx_b, ny_b, nx_c, ny_c, nx_d, ny_d;
    logic signed [31:0] nx_e, ny_e, nx_f, ny_f, nx_g, ny_g;
    logic [63:0]        sqx_b, sqy_b, xym_b;
    logic               xyneg_b;
    logic [36:0]        r2full_next;
    logic [31:0]        r2_c;
    logic signed [31:0] qxx_c, qyy_c, xy_c;
    logic [63:0]        mk1_d, mrr_d, mp1xy_d, mp2xy_d;
    logic               k1neg_d, p1xyneg_d, p2xyneg_d;
    logic signed [31:0] tx_d, ty_d;
    logic signed [31:0] qk1_e, qrr_e, qp1xy_e, qp2xy_e;
    logic [63:0]        mp2tx_e, mp1ty_e;
    logic               p2txneg_e, p1tyneg_e;
    logic [63:0]        mk2rr_f;
    logic               k2neg_f;
    logic signed [31:0] qk1_f, qp1xy_f, qp2xy_f, qp2tx_f, qp1ty_f;
    logic signed [31:0] rf_g;
    logic signed [35:0] sumx_g, sumy_g, sumx_h, sumy_h;
    logic [63:0]        mxrf_h, myrf_h;
    logic               xrfneg_h, yrfneg_h;
    logic signed [31:0] dx_i, dy_i;
    logic [63:0]        mfx_j, mfy_j;
    logic               fxneg_j, fyneg_j;
    logic [64:0]        sq_sum;
    logic signed [35:0] sx_k, sy_k, ox_k, oy_k;
    logic signed [31:0] ox_next, oy_next;
    logic [1:0]         st_next;
    logic [63:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    assign sq_sum      = {1'b0, sqx_b} + {1'b0, sqy_b};
    assign r2full_next = sq_sum[64:28];

    always_comb
    begin
        sx_k    = fxneg_j ? -36'(mfx_j[63:36]) : 36'(mfx_j[63:36]);
        sy_k    = fyneg_j ? -36'(mfy_j[63:36]) : 36'(mfy_j[63:36]);
        ox_k    = sx_k + 36'(pp_reg[23:0]);
        oy_k    = sy_k + 36'(pp_reg[47:24]);
        ox_next = sat36(ox_k);
        oy_next = sat36(oy_k);
        if (pbh_reg[9])
            st_next = ST_BEHIND;
        else if (plim_reg[7])
            st_next = ST_LIMIT;
        else if (!ox_next[31] && 36'(ox_next) < X_END && !oy_next[31] && 36'(oy_next) < Y_END)
            st_next = ST_INSIDE;
        else
            st_next = ST_OUTSIDE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pbh_reg  <= {pbh_reg[8:0], bh_reg[QUOT_W]};
            plim_reg <= {plim_reg[6:0], distorted && (limit_reg != '1)
                         && (r2full_next > 37'(limit_reg))};
            // A
            nx_a <= qsat(qx, ovfx, sx_reg[QUOT_W]);
            ny_a <= qsat(qy, ovfy, sy_reg[QUOT_W]);
            // B
            sqx_b   <= mag32(nx_a) * mag32(nx_a);
            sqy_b   <= mag32(ny_a) * mag32(ny_a);
            xym_b   <= mag32(nx_a) * mag32(ny_a);
            xyneg_b <= nx_a[31] ^ ny_a[31];
            nx_b    <= nx_a;
            ny_b    <= ny_a;
            // C
            r2_c  <= (r2full_next > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r2full_next[31:0];
            qxx_c <= qfin(sqx_b, 1'b0);
            qyy_c <= qfin(sqy_b, 1'b0);
            xy_c  <= qfin(xym_b, xyneg_b);
            nx_c  <= nx_b;
            ny_c  <= ny_b;
            // D
            mk1_d     <= mag32(k1_reg) * r2_c;
            k1neg_d   <= k1_reg[31];
            mrr_d     <= r2_c * r2_c;
            mp1xy_d   <= mag32(p1_reg) * mag32(xy_c);
            p1xyneg_d <= p1_reg[31] ^ xy_c[31];
            mp2xy_d   <= mag32(p2_reg) * mag32(xy_c);
            p2xyneg_d <= p2_reg[31] ^ xy_c[31];
            tx_d      <= sat36(36'(r2_c) + 36'({qxx_c, 1'b0}));
            ty_d      <= sat36(36'(r2_c) + 36'({qyy_c, 1'b0}));
            nx_d      <= nx_c;
            ny_d      <= ny_c;
            // E
            qk1_e     <= qfin(mk1_d, k1neg_d);
            qrr_e     <= qfin(mrr_d, 1'b0);
            qp1xy_e   <= qfin(mp1xy_d, p1xyneg_d);
            qp2xy_e   <= qfin(mp2xy_d, p2xyneg_d);
            mp2tx_e   <= mag32(p2_reg) * mag32(tx_d);
            p2txneg_e <= p2_reg[31] ^ tx_d[31];
            mp1ty_e   <= mag32(p1_reg) * mag32(ty_d);
            p1tyneg_e <= p1_reg[31] ^ ty_d[31];
            nx_e      <= nx_d;
            ny_e      <= ny_d;
            // F
            mk2rr_f <= mag32(k2_reg) * mag32(qrr_e);
            k2neg_f <= k2_reg[31];
            qk1_f   <= qk1_e;
            qp1xy_f <= qp1xy_e;
            qp2xy_f <= qp2xy_e;
            qp2tx_f <= qfin(mp2tx_e, p2txneg_e);
            qp1ty_f <= qfin(mp1ty_e, p1tyneg_e);
            nx_f    <= nx_e;
            ny_f    <= ny_e;
            // G
            rf_g   <= sat36(36'sd268435456 + 36'(qk1_f) + 36'(qfin(mk2rr_f, k2neg_f)));
            sumx_g <= (36'(qp1xy_f) <<< 1) + 36'(qp2tx_f);
            sumy_g <= 36'(qp1ty_f) + (36'(qp2xy_f) <<< 1);
            nx_g   <= nx_f;
            ny_g   <= ny_f;
            // H
            mxrf_h   <= mag32(nx_g) * mag32(rf_g);
            xrfneg_h <= nx_g[31] ^ rf_g[31];
            myrf_h   <= mag32(ny_g) * mag32(rf_g);
            yrfneg_h <= ny_g[31] ^ rf_g[31];
            sumx_h   <= sumx_g;
            sumy_h   <= sumy_g;
            // I
            dx_i <= sat36(36'(qfin(mxrf_h, xrfneg_h)) + sumx_h);
            dy_i <= sat36(36'(qfin(myrf_h, yrfneg_h)) + sumy_h);
            // J
            mfx_j   <= mag32(dx_i) * fx_reg;
            fxneg_j <= dx_i[31];
            mfy_j   <= mag32(dy_i) * fy_reg;
            fyneg_j <= dy_i[31];
            // Output
            m_tuser_reg <= st_next;
            if (pbh_reg[9] || plim_reg[7])
                m_tdata_reg <= '0;
            else
                m_tdata_reg <= {oy_next, ox_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CP2P_ASSERT(a_behind_zero, (m_tvalid && m_tuser == ST_BEHIND) |-> (m_tdata == '0))
    `CP2P_ASSERT(a_limit_zero, (m_tvalid && m_tuser == ST_LIMIT) |-> (m_tdata == '0))
    `CP2P_ASSERT(a_inside_pos, (m_tvalid && m_tuser == ST_INSIDE) |-> (!m_tdata[31] && !m_tdata[63]))
    `CP2P_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready,
                      $stable(pv_reg) && $stable(v_reg[QUOT_W]))

endmodule

/* tb/camera_point_to_pixel_test.sv */
// Self-checking testbench for camera_point_to_pixel: drives camera-frame points, predicts
// pixel position and status in fixed point, and compares every output transaction.
// Depends on cp2p_pkg and the camera_point_to_pixel RTL.
`timescale 1ns / 100ps

module camera_point_to_pixel_test;
    import cp2p_pkg::*;

    localparam int IMG_W = 640;
    localparam int IMG_H = 480;
    localparam int LATENCY = 44;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] pixel_x;
        logic [31:0] pixel_y;
        logic [1:0]  status;
    } pixel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;    // point_x, point_y, point_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // pixel_x, pixel_y
    logic [1:0]  m_tuser;         // status
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [47:0] cfg_wdata = '0;

    logic signed [63:0] coef_k1, coef_k2, coef_p1, coef_p2;
    logic [31:0] scale_fx, scale_fy, limit_r2;
    logic [47:0] center;

    pixel_result_t pending_pixels[$];
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;

    camera_point_to_pixel i_dut (.*);

    always #4 clk = ~clk;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0] m;
        logic signed [63:0] r;
        m = (mag64(a) * mag64(b)) >> 28;
        r = m;
        return clamp32(((a < 0) != (b < 0)) ? -r : r);
    endfunction

    function automatic logic signed [63:0] fix_div(input logic signed [63:0] num,
                                                  input logic signed [63:0] den);
        logic [63:0] q;
        q = (mag64(num) << 28) / den;
        if (num < 0)
            return q > 64'h8000_0000 ? -64'sd2147483648 : -$signed(q);
        return q > 64'h7FFF_FFFF ? 64'sd2147483647 : $signed(q);
    endfunction

    function automatic logic signed [63:0] scale_offset(input logic [31:0] f,
                                                       input logic signed [63:0] v,
                                                       input logic [23:0] off);
        logic [95:0] p;
        logic signed [63:0] s;
        p = 96'(mag64(v)) * 96'(f);
        s = $signed(64'(p >> 36));
        if (v < 0)
            s = -s;
        return clamp32(s + $signed({40'd0, off}));
    endfunction

    function automatic pixel_result_t project_point(input logic [95:0] pt);
        pixel_result_t r;
        logic signed [63:0] px, py, pz, nx, ny, r2, rf, xy, dx, dy, ox, oy;
        logic [63:0] r2full;
        logic distorted;
        px = $signed(pt[31:0]);
        py = $signed(pt[63:32]);
        pz = $signed(pt[95:64]);
        r = '0;
        distorted = coef_k1 != 0 || coef_k2 != 0 || coef_p1 != 0 || coef_p2 != 0;
        if (pz <= 0)
        begin
            r.status = ST_BEHIND;
            return r;
        end
        nx = fix_div(px, pz);
        ny = fix_div(py, pz);
        r2full = (mag64(nx) * mag64(nx) + mag64(ny) * mag64(ny)) >> 28;
        if (distorted && limit_r2 != 32'hFFFF_FFFF && r2full > 64'(limit_r2))
        begin
            r.status = ST_LIMIT;
            return r;
        end
        r2 = r2full > 64'h7FFF_FFFF ? 64'sd2147483647 : $signed(r2full);
        rf = clamp32((64'sd1 <<< 28) + fix_mul(coef_k1, r2) + fix_mul(coef_k2, fix_mul(r2, r2)));
        xy = fix_mul(nx, ny);
        dx = clamp32(fix_mul(nx, rf) + 2 * fix_mul(coef_p1, xy)
                     + fix_mul(coef_p2, clamp32(r2 + 2 * fix_mul(nx, nx))));
        dy = clamp32(fix_mul(ny, rf) + fix_mul(coef_p1, clamp32(r2 + 2 * fix_mul(ny, ny)))
                     + 2 * fix_mul(coef_p2, xy));
        ox = scale_offset(scale_fx, dx, center[23:0]);
        oy = scale_offset(scale_fy, dy, center[47:24]);
        r.pixel_x = ox[31:0];
        r.pixel_y = oy[31:0];
        r.status = (ox >= 0 && ox < IMG_W * 256 && oy >= 0 && oy < IMG_H * 256)
                   ? ST_INSIDE : ST_OUTSIDE;
        return r;
    endfunction

    task automatic write_register(input logic [2:0] addr, input logic [47:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_K1: coef_k1 = $signed(value[31:0]);
            REG_K2: coef_k2 = $signed(value[31:0]);
            REG_P1: coef_p1 = $signed(value[31:0]);
            REG_P2: coef_p2 = $signed(value[31:0]);
            REG_FX: scale_fx = value[31:0];
            REG_FY: scale_fy = value[31:0];
            REG_PP: center = value;
            REG_LIMIT: limit_r2 = value[31:0];
            default: ;
        endcase
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_pixels.insert(pending_pixels.size(), project_point({z, y, x}));
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h0004_0000);
            2: return -$urandom_range(32'h0004_0000);
            default: return $urandom_range(32'h0001_0000) - 32'h0000_8000;
        endcase
    endfunction

    function automatic logic [31:0] random_depth();
        case ($urandom_range(9))
            0: return $urandom;
            1: return -$urandom_range(32'h0001_0000);
            2: return $urandom_range(32'h0000_0100);
            default: return $urandom_range(32'h0010_0000, 32'h0000_4000);
        endcase
    endfunction

    task automatic send_random_points(input int count);
        repeat (count)
            send_point(random_coord(), random_coord(), random_depth());
    endtask

    task automatic configure_camera(input logic [31:0] k1, input logic [31:0] k2,
                                    input logic [31:0] p1, input logic [31:0] p2,
                                    input logic [31:0] fx, input logic [31:0] fy,
                                    input logic [47:0] pp, input logic [31:0] lim);
        drain_pipeline();
        write_register(REG_K1, {16'd0, k1});
        write_register(REG_K2, {16'd0, k2});
        write_register(REG_P1, {16'd0, p1});
        write_register(REG_P2, {16'd0, p2});
        write_register(REG_FX, {16'd0, fx});
        write_register(REG_FY, {16'd0, fy});
        write_register(REG_PP, pp);
        write_register(REG_LIMIT, {16'd0, lim});
    endtask

    task automatic test_reset_defaults();
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'h0);
    endtask

    task automatic test_directed_extremes();
        configure_camera(32'h0, 32'h0, 32'h0, 32'h0, 32'd500 << 16, 32'd500 << 16,
                         {24'd240 << 8, 24'd320 << 8}, 32'hFFFF_FFFF);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000);
        send_point(32'h1000_0000, 32'h0, 32'h0001_0000);
        configure_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h1000_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h0000_1000, 32'h0000_1000, 32'h0001_0000);
        send_point(32'h0002_0000, 32'h0, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'hFFFF_0000);
        configure_camera(32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'd100 << 16, 32'd100 << 16,
                         48'h0, 32'h0);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        send_point(32'h0000_0100, 32'h0, 32'h0001_0000);
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        repeat (phases)
        begin
            configure_camera($urandom_range(3) == 0 ? 32'h0 : $urandom - 32'h8000_0000 >>> 4,
                             $urandom_range(1) ? 32'h0 : $signed($urandom) >>> 5,
                             $urandom_range(1) ? 32'h0 : $signed($urandom) >>> 8,
                             $urandom_range(1) ? 32'h0 : $signed($urandom) >>> 8,
                             $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                             $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0400_0000),
                             {$urandom, $urandom} & 48'h00FF_FFFF_FFFF,
                             $urandom_range(1) ? 32'hFFFF_FFFF : $urandom);
            send_random_points(per_phase);
        end
    endtask

    task automatic test_output_hold_off();
        hold_cycles = 300;
        send_random_points(120);
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        pixel_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[63:32], m_tuser};
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel transaction %h", got);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: x %h/%h y %h/%h status %0d/%0d (expected/actual)",
                                 want.pixel_x, got.pixel_x, want.pixel_y, got.pixel_y,
                                 want.status, got.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        coef_k1 = 0;
        coef_k2 = 0;
        coef_p1 = 0;
        coef_p2 = 0;
        scale_fx = 0;
        scale_fy = 0;
        center = 0;
        limit_r2 = 32'hFFFF_FFFF;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        send_idle_pct = 16;
        recv_idle_pct = 49;
        test_reset_defaults();
        test_directed_extremes();
        test_random_settings(4, 80);
        send_idle_pct = 49;
        recv_idle_pct = 16;
        test_random_settings(4, 80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_hold_off();
        test_random_settings(4, 80);
        drain_pipeline();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
